// File: sv/fts_pkg.sv
// Package for the frame tag stream scanner: item types, event codes,
// register indexes and the keyword tables. Depends on nothing.
package fts_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } fts_in_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  char_out;
        logic [31:0] position;
        logic [5:0]  text_length;
        logic [2:0]  frame_flags;
        logic        unterminated;
    } fts_out_t;

    // Classified byte passed from the front end to the back end.
    typedef struct packed {
        logic       eoi;
        logic [7:0] ch;
        logic       is_lt;
        logic       is_gt;
        logic       is_ws;
        logic       is_sp;
        logic       is_tab;
    } fts_cls_t;

    typedef struct packed {
        logic        en;
        logic [7:0]  index;
        logic [31:0] data;
    } fts_cfg_t;

    localparam logic [7:0] CFG_BASE_OFFSET = 8'd0;
    localparam logic [7:0] CFG_ATTR_EN     = 8'd1;

    localparam logic [2:0] EV_NAME_BYTE   = 3'd0;
    localparam logic [2:0] EV_FRAME_BEGIN = 3'd1;
    localparam logic [2:0] EV_ID_BYTE     = 3'd2;
    localparam logic [2:0] EV_ID_END      = 3'd3;
    localparam logic [2:0] EV_PAR_BYTE    = 3'd4;
    localparam logic [2:0] EV_PAR_END     = 3'd5;
    localparam logic [2:0] EV_FRAME_END   = 3'd6;
    localparam logic [2:0] EV_EOF_NONE    = 3'd7;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [2:0] BEGIN_WORD_LEN = 3'd5;
    localparam logic [2:0] TAG_WORD_LEN   = 3'd6;
    localparam int         KW_COUNT       = 3;

    // "Frame"
    function automatic logic [7:0] begin_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h46;
            3'd1:    return 8'h72;
            3'd2:    return 8'h61;
            3'd3:    return 8'h6D;
            3'd4:    return 8'h65;
            default: return 8'h00;
        endcase
    endfunction

    // "/Frame"
    function automatic logic [7:0] end_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h2F;
            3'd1:    return 8'h46;
            3'd2:    return 8'h72;
            3'd3:    return 8'h61;
            3'd4:    return 8'h6D;
            3'd5:    return 8'h65;
            default: return 8'h00;
        endcase
    endfunction

    // "FrAttr"
    function automatic logic [7:0] attr_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h46;
            3'd1:    return 8'h72;
            3'd2:    return 8'h41;
            3'd3:    return 8'h74;
            3'd4:    return 8'h74;
            3'd5:    return 8'h72;
            default: return 8'h00;
        endcase
    endfunction

    // Keywords "Deleted", "Rename" and "Move".
    function automatic logic [2:0] kw_len(input logic [1:0] k);
        case (k)
            2'd0:    return 3'd7;
            2'd1:    return 3'd6;
            2'd2:    return 3'd4;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0: begin
                case (idx)
                    3'd0:    c = 8'h44;
                    3'd1:    c = 8'h65;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h65;
                    3'd4:    c = 8'h74;
                    3'd5:    c = 8'h65;
                    3'd6:    c = 8'h64;
                    default: c = 8'h00;
                endcase
            end
            2'd1: begin
                case (idx)
                    3'd0:    c = 8'h52;
                    3'd1:    c = 8'h65;
                    3'd2:    c = 8'h6E;
                    3'd3:    c = 8'h61;
                    3'd4:    c = 8'h6D;
                    3'd5:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            2'd2: begin
                case (idx)
                    3'd0:    c = 8'h4D;
                    3'd1:    c = 8'h6F;
                    3'd2:    c = 8'h76;
                    3'd3:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Keywords that no longer match once ch is placed at index idx.
    function automatic logic [2:0] kw_miss(input logic in_range, input logic [2:0] idx,
                                           input logic [7:0] ch);
        logic [2:0] miss;
        miss = 3'b000;
        for (int k = 0; k < KW_COUNT; k++) begin
            miss[k] = !in_range || (idx >= kw_len(2'(k))) || (kw_char(2'(k), idx) != ch);
        end
        return miss;
    endfunction

endpackage

// File: sv/fts_front.sv
// Front end of the frame tag stream scanner: accepts input items and classifies
// each byte into a register. Depends on fts_pkg.
module fts_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fts_pkg::fts_in_t  s_data,
    output logic              f_valid,
    output fts_pkg::fts_cls_t f_entry,
    input  logic              q_ready
);
    import fts_pkg::*;

    logic     f_valid_reg;
    fts_cls_t f_entry_reg;
    fts_cls_t cls_next;

    assign s_ready = !f_valid_reg || q_ready;
    assign f_valid = f_valid_reg;
    assign f_entry = f_entry_reg;

    always_comb begin
        cls_next.eoi    = s_data.end_of_input;
        cls_next.ch     = s_data.data_byte;
        cls_next.is_lt  = s_data.data_byte == CH_LT;
        cls_next.is_gt  = s_data.data_byte == CH_GT;
        cls_next.is_sp  = s_data.data_byte == CH_SPACE;
        cls_next.is_tab = s_data.data_byte == CH_TAB;
        cls_next.is_ws  = s_data.data_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_ready) begin
            f_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            f_entry_reg <= cls_next;
        end
    end

endmodule

// File: sv/fts_queue.sv
// Short queue of classified bytes between the front and back ends of the
// frame tag stream scanner. Depends on fts_pkg.
module fts_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fts_pkg::fts_cls_t push_entry,
    output logic              q_ready,
    input  logic              pop,
    output logic              q_valid,
    output fts_pkg::fts_cls_t q_entry
);
    import fts_pkg::*;

    localparam int Depth = 4;
    localparam int AddrW = $clog2(Depth);

    fts_cls_t         slot_reg [Depth];
    logic [AddrW-1:0] wr_ptr_reg;
    logic [AddrW-1:0] rd_ptr_reg;
    logic [AddrW:0]   count_reg;

    assign q_ready = count_reg != (AddrW + 1)'(Depth);
    assign q_valid = count_reg != '0;
    assign q_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: sv/fts_back.sv
// Back end of the frame tag stream scanner: the scan state machine, the
// configuration registers and the result register. Depends on fts_pkg.
module fts_back #(
    parameter int NAME_MAX = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  fts_pkg::fts_cfg_t cfg_wr,
    input  logic              q_valid,
    input  fts_pkg::fts_cls_t q_entry,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output fts_pkg::fts_out_t m_data
);
    import fts_pkg::*;

    localparam int LenW = $clog2(NAME_MAX);

    typedef enum logic [4:0] {
        ST_START     = 5'd0,
        ST_TAG_OPEN  = 5'd1,
        ST_BEGIN_CMP = 5'd2,
        ST_BEGIN_OK  = 5'd3,
        ST_NAME_SKIP = 5'd4,
        ST_NAME      = 5'd5,
        ST_IN_FRAME  = 5'd6,
        ST_TAG_IN    = 5'd7,
        ST_END_CMP   = 5'd8,
        ST_ATTR_CMP  = 5'd9,
        ST_ATTR_OK   = 5'd10,
        ST_ID_WAIT   = 5'd11,
        ST_ID        = 5'd12,
        ST_PAR_SKIP  = 5'd13,
        ST_PAR       = 5'd14,
        ST_END_OK    = 5'd15,
        ST_END_SKIP  = 5'd16
    } state_t;

    state_t          state_reg, state_next;
    logic [2:0]      match_reg, match_next;
    logic [LenW-1:0] len_reg, len_next;
    logic [31:0]     pos_reg, pos_next;
    logic [31:0]     begin_pos_reg, begin_pos_next;
    logic [2:0]      flags_reg, flags_next;
    logic [2:0]      kw_reg, kw_next;
    logic [31:0]     base_reg;
    logic            attr_en_reg;
    logic            m_valid_reg;
    fts_out_t        m_data_reg;

    logic            res_valid;
    fts_out_t        res;
    logic            store_ok;
    logic [LenW-1:0] len_inc;
    logic [5:0]      len_sat;
    logic [2:0]      kw_after;
    logic [2:0]      kw_hits;
    logic [2:0]      flags_id;
    logic [7:0]      ch;
    logic [7:0]      ch_ws;

    assign pop     = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        ch       = q_entry.ch;
        ch_ws    = q_entry.is_ws ? CH_SPACE : q_entry.ch;
        store_ok = len_reg < LenW'(NAME_MAX - 1);
        len_inc  = len_reg + 1'b1;
        len_sat  = (32'(len_reg) > 32'd63) ? 6'd63 : 6'(len_reg);
        kw_after = kw_reg & ~kw_miss(len_reg < LenW'(7), len_reg[2:0], ch);
        for (int k = 0; k < KW_COUNT; k++) begin
            kw_hits[k] = kw_reg[k] && (len_reg == LenW'(kw_len(2'(k))));
        end
        flags_id = flags_reg | kw_hits;

        state_next     = state_reg;
        match_next     = match_reg;
        len_next       = len_reg;
        pos_next       = pos_reg + 32'd1;
        begin_pos_next = begin_pos_reg;
        flags_next     = flags_reg;
        kw_next        = kw_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (q_entry.eoi) begin
            res_valid = 1'b1;
            if (state_reg >= ST_IN_FRAME) begin
                res.event_res    = EV_FRAME_END;
                res.position     = pos_reg;
                res.frame_flags  = flags_reg;
                res.unterminated = 1'b1;
            end else begin
                res.event_res = EV_EOF_NONE;
            end
            state_next = ST_START;
            match_next = '0;
            len_next   = '0;
            kw_next    = 3'b111;
            pos_next   = base_reg;
        end else begin
            case (state_reg)
                ST_START: begin
                    if (q_entry.is_lt) begin
                        begin_pos_next = pos_reg;
                        state_next     = ST_TAG_OPEN;
                    end
                end
                ST_TAG_OPEN: begin
                    if (ch == CH_COLON) begin
                        len_next   = '0;
                        state_next = ST_NAME;
                    end else if (ch == begin_char(3'd0)) begin
                        match_next = 3'd1;
                        state_next = ST_BEGIN_CMP;
                    end else if (!q_entry.is_ws) begin
                        state_next = ST_START;
                    end
                end
                ST_BEGIN_CMP: begin
                    if (match_reg < BEGIN_WORD_LEN && ch == begin_char(match_reg)) begin
                        match_next = match_reg + 3'd1;
                        if (match_reg + 3'd1 == BEGIN_WORD_LEN) begin
                            state_next = ST_BEGIN_OK;
                        end
                    end else begin
                        match_next = '0;
                        state_next = ST_START;
                    end
                end
                ST_BEGIN_OK: begin
                    len_next   = '0;
                    match_next = '0;
                    if (q_entry.is_gt) begin
                        flags_next     = '0;
                        state_next     = ST_IN_FRAME;
                        res_valid      = 1'b1;
                        res.event_res  = EV_FRAME_BEGIN;
                        res.position   = begin_pos_reg;
                    end else if (q_entry.is_ws) begin
                        state_next = ST_NAME_SKIP;
                    end else begin
                        state_next = ST_START;
                    end
                end
                ST_NAME_SKIP, ST_NAME: begin
                    if (q_entry.is_gt) begin
                        flags_next      = '0;
                        state_next      = ST_IN_FRAME;
                        res_valid       = 1'b1;
                        res.event_res   = EV_FRAME_BEGIN;
                        res.position    = begin_pos_reg;
                        res.text_length = len_sat;
                    end else if (state_reg == ST_NAME || !q_entry.is_ws) begin
                        state_next = q_entry.is_ws ? ST_NAME_SKIP : ST_NAME;
                        if (store_ok) begin
                            len_next      = len_inc;
                            res_valid     = 1'b1;
                            res.event_res = EV_NAME_BYTE;
                            res.char_out  = ch_ws;
                        end
                    end
                end
                ST_IN_FRAME: begin
                    if (q_entry.is_lt) begin
                        state_next = ST_TAG_IN;
                    end
                end
                ST_TAG_IN: begin
                    if (ch == CH_SEMI) begin
                        state_next = ST_END_SKIP;
                    end else if (ch == end_char(3'd0)) begin
                        match_next = 3'd1;
                        state_next = ST_END_CMP;
                    end else if (ch == attr_char(3'd0)) begin
                        match_next = 3'd1;
                        state_next = ST_ATTR_CMP;
                    end else if (!q_entry.is_ws) begin
                        state_next = ST_IN_FRAME;
                    end
                end
                ST_END_CMP: begin
                    if (match_reg < TAG_WORD_LEN && ch == end_char(match_reg)) begin
                        match_next = match_reg + 3'd1;
                        if (match_reg + 3'd1 == TAG_WORD_LEN) begin
                            state_next = ST_END_OK;
                        end
                    end else begin
                        match_next = '0;
                        state_next = ST_IN_FRAME;
                    end
                end
                ST_ATTR_CMP: begin
                    if (match_reg < TAG_WORD_LEN && ch == attr_char(match_reg)) begin
                        match_next = match_reg + 3'd1;
                        if (match_reg + 3'd1 == TAG_WORD_LEN) begin
                            state_next = ST_ATTR_OK;
                        end
                    end else begin
                        match_next = '0;
                        state_next = ST_IN_FRAME;
                    end
                end
                ST_ATTR_OK: begin
                    len_next   = '0;
                    match_next = '0;
                    kw_next    = 3'b111;
                    state_next = q_entry.is_sp ? ST_ID_WAIT : ST_IN_FRAME;
                end
                ST_ID_WAIT, ST_ID: begin
                    if (q_entry.is_gt || (state_reg == ST_ID && q_entry.is_ws)) begin
                        if (state_reg == ST_ID) begin
                            state_next = q_entry.is_gt ? ST_IN_FRAME : ST_PAR_SKIP;
                            flags_next = flags_id;
                            len_next   = '0;
                            if (attr_en_reg) begin
                                res_valid       = 1'b1;
                                res.event_res   = EV_ID_END;
                                res.text_length = len_sat;
                                res.frame_flags = flags_id;
                            end
                        end else begin
                            state_next = ST_IN_FRAME;
                        end
                    end else if (state_reg == ST_ID || (!q_entry.is_sp && !q_entry.is_tab)) begin
                        state_next = ST_ID;
                        kw_next    = kw_after;
                        if (store_ok) begin
                            len_next = len_inc;
                            if (attr_en_reg) begin
                                res_valid     = 1'b1;
                                res.event_res = EV_ID_BYTE;
                                res.char_out  = ch;
                            end
                        end
                    end
                end
                ST_PAR_SKIP, ST_PAR: begin
                    if (q_entry.is_gt) begin
                        len_next   = '0;
                        state_next = ST_IN_FRAME;
                        if (attr_en_reg) begin
                            res_valid       = 1'b1;
                            res.event_res   = EV_PAR_END;
                            res.text_length = len_sat;
                        end
                    end else if (state_reg == ST_PAR || !q_entry.is_ws) begin
                        state_next = q_entry.is_ws ? ST_PAR_SKIP : ST_PAR;
                        if (store_ok) begin
                            len_next = len_inc;
                            if (attr_en_reg) begin
                                res_valid     = 1'b1;
                                res.event_res = EV_PAR_BYTE;
                                res.char_out  = ch_ws;
                            end
                        end
                    end
                end
                ST_END_OK, ST_END_SKIP: begin
                    if (q_entry.is_gt) begin
                        state_next      = ST_START;
                        match_next      = '0;
                        res_valid       = 1'b1;
                        res.event_res   = EV_FRAME_END;
                        res.position    = pos_reg;
                        res.frame_flags = flags_reg;
                    end else if (state_reg == ST_END_OK) begin
                        if (q_entry.is_ws) begin
                            state_next = ST_END_SKIP;
                        end else begin
                            match_next = '0;
                            state_next = ST_IN_FRAME;
                        end
                    end
                end
                default: begin
                    state_next = ST_START;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_START;
            match_reg     <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            begin_pos_reg <= '0;
            flags_reg     <= '0;
            kw_reg        <= 3'b111;
            base_reg      <= '0;
            attr_en_reg   <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                state_reg     <= state_next;
                match_reg     <= match_next;
                len_reg       <= len_next;
                pos_reg       <= pos_next;
                begin_pos_reg <= begin_pos_next;
                flags_reg     <= flags_next;
                kw_reg        <= kw_next;
            end
            if (cfg_wr.en && cfg_wr.index == CFG_BASE_OFFSET) begin
                base_reg <= cfg_wr.data;
                pos_reg  <= cfg_wr.data;
            end
            if (cfg_wr.en && cfg_wr.index == CFG_ATTR_EN) begin
                attr_en_reg <= cfg_wr.data[0];
            end
            if (pop) begin
                m_valid_reg <= res_valid;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (pop && res_valid) begin
            m_data_reg <= res;
        end
    end

endmodule

// File: sv/frame_tag_stream_scanner.sv
// Frame tag stream scanner, top level. One byte per cycle is sustained while the
// output is not stalled; a result passes through the input register, the queue
// and a scan state step into the result register. The scan state machine takes
// one item per cycle and sets the rate; a four-entry queue separates it from the
// input. Reset (aresetn, synchronous, active low) empties the queue and result
// register and returns the scanner to its start state with base offset zero.
module frame_tag_stream_scanner #(
    parameter int NAME_MAX = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fts_pkg::fts_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fts_pkg::fts_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import fts_pkg::*;

    logic     f_valid;
    fts_cls_t f_entry;
    logic     q_ready;
    logic     q_valid;
    fts_cls_t q_entry;
    logic     pop;
    fts_cfg_t cfg_wr;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.en    = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    fts_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_entry (f_entry),
        .q_ready (q_ready)
    );

    fts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_valid && q_ready),
        .push_entry (f_entry),
        .q_ready    (q_ready),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    fts_back #(
        .NAME_MAX (NAME_MAX)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A full queue must hold at least one item.
    assert property (@(posedge aclk) disable iff (!aresetn) !q_ready |-> q_valid)
        else $error("queue reports full while empty");

    // The scanner never steps while a result is stalled at the output.
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> (!m_valid || m_ready))
        else $error("scanner stepped over a stalled result");

    // A classified byte that the queue refuses is held for the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid && !q_ready |=> f_valid && $stable(f_entry))
        else $error("front end lost an item while the queue was full");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for frame_tag_stream_scanner: directed and random byte streams checked
// against a scanner model held in the bench. Depends on fts_pkg and the scanner RTL.
module tb_top;
    import fts_pkg::*;

    localparam int NAME_LIMIT    = 64;
    localparam int TEXT_LEN_MAX  = 63;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int RANDOM_PHASES = 6;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [4:0] {
        SC_START, SC_TAG_OPEN, SC_BEGIN_CMP, SC_BEGIN_OK, SC_NAME_SKIP, SC_NAME,
        SC_IN_FRAME, SC_TAG_IN, SC_END_CMP, SC_ATTR_CMP, SC_ATTR_OK, SC_ID_WAIT,
        SC_ID, SC_PAR_SKIP, SC_PAR, SC_END_OK, SC_END_SKIP
    } scan_state_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SLOW} rx_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    fts_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    fts_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    frame_tag_stream_scanner #(.NAME_MAX(NAME_LIMIT)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    fts_out_t    pending_events[$];
    fts_out_t    head_event;
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    int          burst_left     = 0;
    bit          sender_steady  = 1'b0;
    int          stall_cycles   = 0;
    rx_mode_t    rx_mode        = RX_OPEN;
    int          rx_left        = 0;
    int unsigned rx_phase       = 0;

    // Scanner model state and configuration.
    logic [31:0] base_pos;
    bit          attr_on;
    scan_state_t model_scan;
    int unsigned model_match;
    int unsigned model_len;
    logic [31:0] model_pos;
    logic [31:0] model_begin_pos;
    logic [2:0]  model_flags;
    logic [2:0]  model_kw_live;

    string open_word  = "Frame";
    string close_word = "/Frame";
    string attr_word  = "FrAttr";

    function automatic string flag_word(int k);
        case (k)
            0:       return "Deleted";
            1:       return "Rename";
            default: return "Move";
        endcase
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic string describe(fts_out_t r);
        return $sformatf("ev %0d ch %h pos %h len %0d flags %b unterm %b", r.event_res,
                         r.char_out, r.position, r.text_length, r.frame_flags,
                         r.unterminated);
    endfunction

    function automatic void reset_model();
        base_pos        = '0;
        attr_on         = 1'b1;
        model_scan      = SC_START;
        model_match     = 0;
        model_len       = 0;
        model_pos       = '0;
        model_begin_pos = '0;
        model_flags     = '0;
        model_kw_live   = 3'b111;
    endfunction

    function automatic void queue_event(logic [2:0] ev, logic [7:0] ch, logic [31:0] pos,
                                        int unsigned len, logic [2:0] flg, logic unt);
        fts_out_t r;
        r.event_res    = ev;
        r.char_out     = ch;
        r.position     = pos;
        r.text_length  = (len > TEXT_LEN_MAX) ? 6'(TEXT_LEN_MAX) : 6'(len);
        r.frame_flags  = flg;
        r.unterminated = unt;
        pending_events.push_back(r);
    endfunction

    function automatic bit keep_char();
        if (model_len + 1 < NAME_LIMIT) begin
            model_len++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_keywords(logic [7:0] c);
        string w;
        for (int k = 0; k < KW_COUNT; k++) begin
            w = flag_word(k);
            if (model_len >= w.len() || w[model_len] != c)
                model_kw_live[k] = 1'b0;
        end
    endfunction

    function automatic void open_frame();
        model_flags = '0;
        model_scan  = SC_IN_FRAME;
        queue_event(EV_FRAME_BEGIN, 8'h00, model_begin_pos, model_len, 3'b000, 1'b0);
    endfunction

    function automatic void close_id();
        int unsigned len;
        string w;
        len = model_len;
        for (int k = 0; k < KW_COUNT; k++) begin
            w = flag_word(k);
            if (model_kw_live[k] && len == w.len())
                model_flags[k] = 1'b1;
        end
        model_len = 0;
        if (attr_on)
            queue_event(EV_ID_END, 8'h00, 32'h0, len, model_flags, 1'b0);
    endfunction

    function automatic void close_param();
        int unsigned len;
        len        = model_len;
        model_len  = 0;
        model_scan = SC_IN_FRAME;
        if (attr_on)
            queue_event(EV_PAR_END, 8'h00, 32'h0, len, 3'b000, 1'b0);
    endfunction

    function automatic void close_frame(logic [31:0] pos, logic unt);
        model_scan  = SC_START;
        model_match = 0;
        queue_event(EV_FRAME_END, 8'h00, pos, 0, model_flags, unt);
    endfunction

    function automatic void scan_model_step(logic [7:0] c_in, logic eoi);
        logic [7:0]  c;
        logic [31:0] pos;
        c   = c_in;
        pos = model_pos;
        if (eoi) begin
            if (model_scan >= SC_IN_FRAME)
                close_frame(pos, 1'b1);
            else
                queue_event(EV_EOF_NONE, 8'h00, 32'h0, 0, 3'b000, 1'b0);
            model_scan    = SC_START;
            model_match   = 0;
            model_len     = 0;
            model_kw_live = 3'b111;
            model_pos     = base_pos;
            return;
        end
        model_pos = pos + 32'd1;
        case (model_scan)
            SC_START: begin
                if (c == CH_LT) begin
                    model_begin_pos = pos;
                    model_scan      = SC_TAG_OPEN;
                end
            end
            SC_TAG_OPEN: begin
                if (c == CH_COLON) begin
                    model_len  = 0;
                    model_scan = SC_NAME;
                end else if (c == open_word[0]) begin
                    model_match = 1;
                    model_scan  = SC_BEGIN_CMP;
                end else if (!is_space(c)) begin
                    model_scan = SC_START;
                end
            end
            SC_BEGIN_CMP: begin
                if (model_match < open_word.len() && c == open_word[model_match]) begin
                    model_match++;
                    if (model_match == open_word.len())
                        model_scan = SC_BEGIN_OK;
                end else begin
                    model_match = 0;
                    model_scan  = SC_START;
                end
            end
            SC_BEGIN_OK: begin
                model_len   = 0;
                model_match = 0;
                if (c == CH_GT)
                    open_frame();
                else if (is_space(c))
                    model_scan = SC_NAME_SKIP;
                else
                    model_scan = SC_START;
            end
            SC_NAME_SKIP: begin
                if (c == CH_GT) begin
                    open_frame();
                end else if (!is_space(c)) begin
                    model_scan = SC_NAME;
                    if (keep_char())
                        queue_event(EV_NAME_BYTE, c, 32'h0, 0, 3'b000, 1'b0);
                end
            end
            SC_NAME: begin
                if (c == CH_GT) begin
                    open_frame();
                end else begin
                    if (is_space(c)) begin
                        c          = CH_SPACE;
                        model_scan = SC_NAME_SKIP;
                    end
                    if (keep_char())
                        queue_event(EV_NAME_BYTE, c, 32'h0, 0, 3'b000, 1'b0);
                end
            end
            SC_IN_FRAME: begin
                if (c == CH_LT)
                    model_scan = SC_TAG_IN;
            end
            SC_TAG_IN: begin
                if (c == CH_SEMI) begin
                    model_scan = SC_END_SKIP;
                end else if (c == close_word[0]) begin
                    model_match = 1;
                    model_scan  = SC_END_CMP;
                end else if (c == attr_word[0]) begin
                    model_match = 1;
                    model_scan  = SC_ATTR_CMP;
                end else if (!is_space(c)) begin
                    model_scan = SC_IN_FRAME;
                end
            end
            SC_END_CMP: begin
                if (model_match < close_word.len() && c == close_word[model_match]) begin
                    model_match++;
                    if (model_match == close_word.len())
                        model_scan = SC_END_OK;
                end else begin
                    model_match = 0;
                    model_scan  = SC_IN_FRAME;
                end
            end
            SC_ATTR_CMP: begin
                if (model_match < attr_word.len() && c == attr_word[model_match]) begin
                    model_match++;
                    if (model_match == attr_word.len())
                        model_scan = SC_ATTR_OK;
                end else begin
                    model_match = 0;
                    model_scan  = SC_IN_FRAME;
                end
            end
            SC_ATTR_OK: begin
                model_len     = 0;
                model_match   = 0;
                model_kw_live = 3'b111;
                model_scan    = (c == CH_SPACE) ? SC_ID_WAIT : SC_IN_FRAME;
            end
            SC_ID_WAIT: begin
                if (c == CH_GT) begin
                    model_scan = SC_IN_FRAME;
                end else if (c != CH_SPACE && c != CH_TAB) begin
                    model_scan = SC_ID;
                    check_keywords(c);
                    if (keep_char() && attr_on)
                        queue_event(EV_ID_BYTE, c, 32'h0, 0, 3'b000, 1'b0);
                end
            end
            SC_ID: begin
                if (c == CH_GT) begin
                    model_scan = SC_IN_FRAME;
                    close_id();
                end else if (is_space(c)) begin
                    model_scan = SC_PAR_SKIP;
                    close_id();
                end else begin
                    check_keywords(c);
                    if (keep_char() && attr_on)
                        queue_event(EV_ID_BYTE, c, 32'h0, 0, 3'b000, 1'b0);
                end
            end
            SC_PAR_SKIP: begin
                if (c == CH_GT) begin
                    close_param();
                end else if (!is_space(c)) begin
                    model_scan = SC_PAR;
                    if (keep_char() && attr_on)
                        queue_event(EV_PAR_BYTE, c, 32'h0, 0, 3'b000, 1'b0);
                end
            end
            SC_PAR: begin
                if (c == CH_GT) begin
                    close_param();
                end else begin
                    if (is_space(c)) begin
                        c          = CH_SPACE;
                        model_scan = SC_PAR_SKIP;
                    end
                    if (keep_char() && attr_on)
                        queue_event(EV_PAR_BYTE, c, 32'h0, 0, 3'b000, 1'b0);
                end
            end
            SC_END_OK: begin
                if (c == CH_GT) begin
                    close_frame(pos, 1'b0);
                end else if (is_space(c)) begin
                    model_scan = SC_END_SKIP;
                end else begin
                    model_match = 0;
                    model_scan  = SC_IN_FRAME;
                end
            end
            SC_END_SKIP: begin
                if (c == CH_GT)
                    close_frame(pos, 1'b0);
            end
            default: model_scan = SC_START;
        endcase
    endfunction

    // Stream driving. Every task starts and ends at a falling edge.
    task automatic send_item(input logic [7:0] b, input logic eoi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid             <= 1'b1;
        s_data.data_byte    <= b;
        s_data.end_of_input <= eoi;
        do @(posedge aclk); while (!s_ready);
        scan_model_step(b, eoi);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_eoi();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_BASE_OFFSET) begin
            base_pos  = value;
            model_pos = value;
        end else if (idx == CFG_ATTR_EN) begin
            attr_on = value[0];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] rand_id_char();
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 3) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = 8'($urandom_range(8'h41, 8'h7A));
        end while (is_space(c) || c == CH_GT);
        return c;
    endfunction

    function automatic logic [7:0] rand_name_char();
        if ($urandom_range(0, 4) == 0)
            return rand_space();
        return rand_id_char();
    endfunction

    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_LT);
        return c;
    endfunction

    task automatic send_attribute();
        int n;
        send_text("<FrAttr");
        send_item(($urandom_range(0, 9) == 0) ? rand_space() : CH_SPACE, 1'b0);
        repeat ($urandom_range(0, 2)) send_item($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
        case ($urandom_range(0, 5))
            0, 1, 2: send_text(flag_word($urandom_range(0, 2)));
            3: begin
                send_text(flag_word($urandom_range(0, 2)));
                send_item(rand_id_char(), 1'b0);
            end
            default: begin
                n = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
                repeat (n) send_item(rand_id_char(), 1'b0);
            end
        endcase
        if ($urandom_range(0, 2) != 0) begin
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(1, 3)) send_item(rand_space(), 1'b0);
                repeat ($urandom_range(1, 6)) send_item(rand_id_char(), 1'b0);
            end
            if ($urandom_range(0, 1) == 0)
                send_item(rand_space(), 1'b0);
        end
        send_item(CH_GT, 1'b0);
    endtask

    task automatic send_random_frame();
        int n;
        if ($urandom_range(0, 2) == 0) begin
            send_text("<:");
        end else begin
            send_text("<Frame");
            repeat ($urandom_range(1, 3)) send_item(rand_space(), 1'b0);
        end
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 8);
        repeat (n) send_item(rand_name_char(), 1'b0);
        send_item(CH_GT, 1'b0);
        repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(0, 5)) send_item(rand_text_char(), 1'b0);
            case ($urandom_range(0, 5))
                0: begin
                    send_text("<Fr");
                    send_item(rand_text_char(), 1'b0);
                end
                1: begin
                    send_text("</Fram");
                    send_item(rand_id_char(), 1'b0);
                end
                default: send_attribute();
            endcase
        end
        case ($urandom_range(0, 9))
            0: send_eoi();
            1, 2, 3, 4: begin
                send_text("</Frame");
                if ($urandom_range(0, 1) == 0) begin
                    send_item(rand_space(), 1'b0);
                    repeat ($urandom_range(0, 4)) send_item(rand_id_char(), 1'b0);
                end
                send_item(CH_GT, 1'b0);
            end
            5, 6, 7: begin
                send_text("<;");
                repeat ($urandom_range(0, 4)) send_item(rand_id_char(), 1'b0);
                send_item(CH_GT, 1'b0);
            end
            8: send_text("</Fram>");
            default: ;
        endcase
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 11))
                0: send_item(CH_LT, 1'b0);
                1: send_text("<Fr");
                2: send_text("</Fra");
                3: send_text("<FrAttr");
                4: send_eoi();
                default: send_item(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
    endtask

    task automatic test_long_form_frame();
        send_text("<Frame ");
        send_item(CH_TAB, 1'b0);
        send_text("Ab");
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        send_text(" c>x<FrAttr Deleted p  q><FrAttr Rename><FrAttr Move ></Frame>");
    endtask

    task automatic test_short_form_frame();
        send_text("<:");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("><FrAttr ><FrAttr");
        send_item(CH_TAB, 1'b0);
        send_text("Move><FrAttr ");
        send_item(CH_CR, 1'b0);
        send_text("id");
        send_item(CH_LF, 1'b0);
        send_text("v ><FrAttr Moves><;x>");
    endtask

    task automatic test_mismatched_tags();
        send_text("<<Frame>< Frame A><</Frame><FrAttr<Frame></Framex></Frame junk>");
    endtask

    task automatic test_end_of_input();
        send_eoi();
        send_text("<:a");
        send_eoi();
        send_text("<Frame><FrAttr Del");
        send_eoi();
        send_eoi();
    endtask

    task automatic test_truncation();
        send_text("<:");
        repeat (NAME_LIMIT + 6) send_item(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
        send_text("><FrAttr ");
        repeat (NAME_LIMIT + 6) send_item(rand_id_char(), 1'b0);
        send_item(CH_SPACE, 1'b0);
        repeat (NAME_LIMIT + 6) send_item(rand_id_char(), 1'b0);
        send_text("><;>");
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_BASE_OFFSET, 32'hFFFF_FFFF);
        write_reg(CFG_ATTR_EN, 32'd0);
        send_text("<:w><FrAttr Deleted p><FrAttr Move></Frame><:v>");
        send_eoi();
        write_reg(CFG_ATTR_EN, 32'd1);
        write_reg(CFG_BASE_OFFSET, 32'd0);
        send_text("<:z><FrAttr Rename q>");
        send_eoi();
    endtask

    task automatic test_random_streams();
        int start_count;
        logic [31:0] offset;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 3)
                0:       offset = 32'hFFFF_FFF0;
                1:       offset = $urandom();
                default: offset = (p == 2) ? 32'h0 : 32'hFFFF_FFFF;
            endcase
            write_reg(CFG_BASE_OFFSET, offset);
            write_reg(CFG_ATTR_EN, (p % 3 == 1) ? 32'd0 : 32'd1);
            sender_steady = (p == 1);
            start_count = bytes_sent;
            while (bytes_sent - start_count < RANDOM_ITEMS / RANDOM_PHASES) begin
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    send_random_frame();
            end
        end
        sender_steady = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 256);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN: m_ready <= 1'b1;
            RX_COIN: m_ready <= ($urandom_range(0, 1) == 1);
            RX_COMB: m_ready <= (rx_phase % 4 != 3);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result %s", $realtime, describe(m_data));
            end else begin
                head_event = pending_events.pop_front();
                if (m_data.event_res !== head_event.event_res
                        || m_data.char_out !== head_event.char_out
                        || m_data.position !== head_event.position
                        || m_data.text_length !== head_event.text_length
                        || m_data.frame_flags !== head_event.frame_flags
                        || m_data.unterminated !== head_event.unterminated) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: expected %s", $realtime, describe(head_event));
                        $display("%0t: actual   %s", $realtime, describe(m_data));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("frame_tag_stream_scanner verification failed");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        test_long_form_frame();
        test_short_form_frame();
        test_mismatched_tags();
        test_end_of_input();
        test_truncation();
        test_config_extremes();
        test_random_streams();
        wait_idle();
        if (mismatch_count == 0)
            $display("frame_tag_stream_scanner verification clean");
        else
            $display("frame_tag_stream_scanner verification failed");
        $finish;
    end

endmodule
